FILE: design/tfr_pkg.sv
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared types, constants and byte-lane helpers for the tile row fetch block.
// ----------------------------------------------------------------------------
package tfr_pkg;

  // Store geometry
  localparam int TILE_COUNT  = 1024;
  localparam int STORE_WORDS = 16384;
  localparam int ADDR_W      = $clog2(STORE_WORDS);

  // Field widths fixed by the transaction format
  localparam int REQ_AW = 14;
  localparam int TILE_W = 10;

  typedef logic [ADDR_W-1:0] addr_t;

  // Request codes
  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_RENDER = 2'd1,
    REQ_STORE  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // Blank grid patterns
  localparam logic [63:0] GRID4_EVEN = 64'h0000_0000_0101_0101;
  localparam logic [63:0] GRID4_ODD  = 64'h0000_0000_1010_1010;
  localparam logic [63:0] GRID8_EVEN = 64'h0100_0100_0100_0100;
  localparam logic [63:0] GRID8_ODD  = 64'h0001_0001_0001_0001;

  localparam logic [3:0] BYTES_NONE = 4'd0;
  localparam logic [3:0] BYTES_4BPP = 4'd4;
  localparam logic [3:0] BYTES_8BPP = 4'd8;

  // Input transaction
  typedef struct packed {
    logic [1:0]        req_type;
    logic [REQ_AW-1:0] load_address;
    logic [31:0]       load_word;
    logic [TILE_W-1:0] tile_index;
    logic              hflip;
    logic              vflip;
    logic              blank;
    logic [2:0]        pixel_row;
    logic [31:0]       bitmap_row;
  } req_t;

  // Result transaction
  typedef struct packed {
    logic [63:0] row_pixels;
    logic [3:0]  row_bytes;
  } res_t;

  // Sequencer to formatter
  typedef struct packed {
    logic fin;     // read data of the current item is on the RAM output
    logic cap_lo;  // RAM output holds the low word of an 8bpp row
    logic render;
    logic mode8;
    logic blank;
    logic hflip;
    logic odd;
    logic lo_ok;
    logic hi_ok;
  } fmt_ctrl_t;

  function automatic logic [31:0] swap_nibbles(logic [31:0] w);
    return ((w & 32'h0F0F_0F0F) << 4) | ((w >> 4) & 32'h0F0F_0F0F);
  endfunction

  function automatic logic [31:0] reverse_bytes(logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic addr_in_range(logic [REQ_AW-1:0] a);
    return {3'b000, a} < 17'(STORE_WORDS);
  endfunction

  function automatic logic tile_in_range(logic [TILE_W-1:0] t);
    return {1'b0, t} < 11'(TILE_COUNT);
  endfunction

endpackage

FILE: design/tfr_ram.sv
// ----------------------------------------------------------------------------
// tfr_ram
// Generic single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module tfr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/tfr_ctrl.sv
// ----------------------------------------------------------------------------
// tfr_ctrl
// Sequencer: accepts transactions, forms tile store addresses, drives the RAM
// port and tells the formatter what the RAM output holds.
// ----------------------------------------------------------------------------
module tfr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  tfr_pkg::req_t       req_i,
  input  logic                mode_i,
  output logic                busy_o,
  output logic                ram_en_o,
  output logic                ram_we_o,
  output tfr_pkg::addr_t      ram_addr_o,
  output logic [31:0]         ram_wdata_o,
  output tfr_pkg::fmt_ctrl_t  fmt_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_HI   = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic                      accept;
  logic                      is_load, is_render, is_store;
  logic                      tile_ok;
  logic [2:0]                trow;
  logic [tfr_pkg::REQ_AW-1:0] addr4, addr_lo8, addr_hi8, rd_addr;
  logic                      two_reads;

  // item registers
  logic                       render_q, mode8_q, blank_q, hflip_q, odd_q;
  logic                       lo_ok_q, hi_ok_q;
  logic [tfr_pkg::REQ_AW-1:0] hi_addr_q;

  assign accept    = start_i && !busy_o;
  assign busy_o    = (state_q == S_HI);
  assign is_load   = (req_i.req_type == tfr_pkg::REQ_LOAD);
  assign is_render = (req_i.req_type == tfr_pkg::REQ_RENDER);
  assign is_store  = (req_i.req_type == tfr_pkg::REQ_STORE);
  assign tile_ok   = tfr_pkg::tile_in_range(req_i.tile_index);

  // tile row, mirrored with vflip
  assign trow     = req_i.pixel_row ^ {3{req_i.vflip}};
  assign addr4    = tfr_pkg::REQ_AW'({req_i.tile_index, trow});
  assign addr_lo8 = {req_i.tile_index, trow, 1'b0};
  assign addr_hi8 = {req_i.tile_index, trow, 1'b1};
  assign rd_addr  = mode_i ? addr_lo8 : addr4;

  assign two_reads = is_render && mode_i && !req_i.blank;

  // RAM port: accept cycle uses the inputs, high-word cycle the registers
  always_comb begin
    ram_en_o    = 1'b0;
    ram_we_o    = 1'b0;
    ram_addr_o  = tfr_pkg::addr_t'(rd_addr);
    ram_wdata_o = req_i.load_word;
    if (state_q == S_HI) begin
      ram_en_o   = 1'b1;
      ram_addr_o = tfr_pkg::addr_t'(hi_addr_q);
    end else if (accept) begin
      if (is_load) begin
        ram_en_o   = tfr_pkg::addr_in_range(req_i.load_address);
        ram_we_o   = 1'b1;
        ram_addr_o = tfr_pkg::addr_t'(req_i.load_address);
      end else if (is_store) begin
        ram_en_o    = !mode_i && !req_i.blank && tile_ok && tfr_pkg::addr_in_range(addr4);
        ram_we_o    = 1'b1;
        ram_addr_o  = tfr_pkg::addr_t'(addr4);
        ram_wdata_o = req_i.hflip ? tfr_pkg::reverse_bytes(req_i.bitmap_row)
                                  : tfr_pkg::swap_nibbles(req_i.bitmap_row);
      end else if (is_render) begin
        ram_en_o = !req_i.blank;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE, S_FIN: begin
        if (accept) begin
          state_d = two_reads ? S_HI : S_FIN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_HI:    state_d = S_FIN;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // per-item flags, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      render_q  <= is_render;
      mode8_q   <= mode_i;
      blank_q   <= req_i.blank;
      hflip_q   <= req_i.hflip;
      odd_q     <= req_i.pixel_row[0];
      lo_ok_q   <= tile_ok && tfr_pkg::addr_in_range(rd_addr);
      hi_ok_q   <= tile_ok && tfr_pkg::addr_in_range(addr_hi8);
      hi_addr_q <= addr_hi8;
    end
  end

  assign fmt_o.fin    = (state_q == S_FIN);
  assign fmt_o.cap_lo = (state_q == S_HI);
  assign fmt_o.render = render_q;
  assign fmt_o.mode8  = mode8_q;
  assign fmt_o.blank  = blank_q;
  assign fmt_o.hflip  = hflip_q;
  assign fmt_o.odd    = odd_q;
  assign fmt_o.lo_ok  = lo_ok_q;
  assign fmt_o.hi_ok  = hi_ok_q;

endmodule

FILE: design/tfr_fmt.sv
// ----------------------------------------------------------------------------
// tfr_fmt
// Result formatter: builds the bitmap row from the tile store words or a grid
// pattern, applies hflip or 4bpp nibble swap, registers the result transaction.
// ----------------------------------------------------------------------------
module tfr_fmt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tfr_pkg::fmt_ctrl_t ctrl_i,
  input  logic [31:0]        rdata_i,
  output logic               res_valid_o,
  output tfr_pkg::res_t      res_o
);

  logic [31:0]   lo_q;
  logic [31:0]   lo_w, hi_w, one_w;
  tfr_pkg::res_t res_d, res_q;
  logic          valid_q;

  // low word of an 8bpp row arrives in the cycle before the high word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap_lo) begin
      lo_q <= rdata_i;
    end
  end

  assign lo_w  = ctrl_i.lo_ok ? lo_q    : 32'h0;
  assign hi_w  = ctrl_i.hi_ok ? rdata_i : 32'h0;
  assign one_w = ctrl_i.lo_ok ? rdata_i : 32'h0;

  // row assembly
  always_comb begin
    res_d.row_pixels = 64'h0;
    res_d.row_bytes  = tfr_pkg::BYTES_NONE;
    if (ctrl_i.render) begin
      if (ctrl_i.mode8) begin
        res_d.row_bytes = tfr_pkg::BYTES_8BPP;
        if (ctrl_i.blank) begin
          res_d.row_pixels = ctrl_i.odd ? tfr_pkg::GRID8_ODD : tfr_pkg::GRID8_EVEN;
        end else if (ctrl_i.hflip) begin
          res_d.row_pixels = {tfr_pkg::reverse_bytes(lo_w), tfr_pkg::reverse_bytes(hi_w)};
        end else begin
          res_d.row_pixels = {hi_w, lo_w};
        end
      end else begin
        res_d.row_bytes = tfr_pkg::BYTES_4BPP;
        if (ctrl_i.blank) begin
          res_d.row_pixels = ctrl_i.odd ? tfr_pkg::GRID4_ODD : tfr_pkg::GRID4_EVEN;
        end else if (ctrl_i.hflip) begin
          res_d.row_pixels = {32'h0, tfr_pkg::reverse_bytes(one_w)};
        end else begin
          res_d.row_pixels = {32'h0, tfr_pkg::swap_nibbles(one_w)};
        end
      end
    end
  end

  // result register and strobe
  always_ff @(posedge clk_i) begin
    if (ctrl_i.fin) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_i.fin;
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: design/tile_row_fetch_with_flip_core.sv
// ----------------------------------------------------------------------------
// tile_row_fetch_with_flip_core
// Tile store with 4bpp / 8bpp bitmap row fetch, flip and 4bpp row write-back.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                      Payload
//  request   in         start_i && !busy_o             req_i       (req_t)
//  result    out        res_valid_o, one-cycle strobe  res_o       (res_t)
//  config    in         cfg_we_i                       cfg_wdata_i (color_mode)
//
// Each transaction gives one result, registered with its strobe from the
// S_FIN state; an 8bpp non-blank render goes through S_HI first. busy_o is
// high only in the cycle that reads the high word of an 8bpp row, so 4bpp
// items run at one per cycle, and an 8bpp non-blank render holds off the next
// request while its high word is read: the single RAM port carries one access
// a cycle. Reset clears the sequencer, the strobe and color_mode; the tile
// store is not cleared. The receiver cannot stall the result strobe.
//
module tile_row_fetch_with_flip_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  tfr_pkg::req_t req_i,
  output logic          res_valid_o,
  output tfr_pkg::res_t res_o,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i
);

  logic               mode_q;
  logic               ram_en, ram_we;
  tfr_pkg::addr_t     ram_addr;
  logic [31:0]        ram_wdata, ram_rdata;
  tfr_pkg::fmt_ctrl_t fmt_ctrl;

  // colour mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  tfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .mode_i      (mode_q),
    .busy_o      (busy_o),
    .ram_en_o    (ram_en),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .fmt_o       (fmt_ctrl)
  );

  // tile store
  tfr_ram #(
    .WIDTH (32),
    .DEPTH (tfr_pkg::STORE_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  tfr_fmt u_fmt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (fmt_ctrl),
    .rdata_i     (ram_rdata),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // the high-word read never lasts longer than one cycle
  a_busy_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o) else $error("busy held for more than one cycle");

  // every accepted transaction is followed by its result strobe
  a_accept_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##[1:2] res_valid_o)
    else $error("accepted transaction made no progress");

  // the high-word read is followed by the result strobe
  a_hi_then_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> ##1 res_valid_o) else $error("8bpp render lost its result");

  // an 8bpp non-blank render must take the high-word cycle
  a_8bpp_two_reads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && mode_q && !req_i.blank &&
     req_i.req_type == tfr_pkg::REQ_RENDER) |=> busy_o)
    else $error("8bpp render skipped the high word read");

endmodule

FILE: tb/tile_row_fetch_with_flip_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_row_fetch_with_flip_core_test
// Self-checking bench for the tile row fetch block. A short directed table
// covers grid patterns, flips, write-back and unknown requests in both colour
// modes. Random phases then alternate the colour mode, mixing loads, renders
// and stores on a small pool of tiles. Every result is checked against the
// row the table gives or, if none, a behavioural copy of the tile store.
// ----------------------------------------------------------------------------
module tile_row_fetch_with_flip_core_test;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 255;
  localparam int POOL_TILES   = 6;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          start_i     = 1'b0;
  logic          busy_o;
  tfr_pkg::req_t req_i       = '0;
  logic          res_valid_o;
  tfr_pkg::res_t res_o;
  logic          cfg_we_i    = 1'b0;
  logic          cfg_wdata_i = 1'b0;

  tile_row_fetch_with_flip_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Behavioural tile store and colour mode
  logic [31:0] tile_mem    [tfr_pkg::STORE_WORDS];
  bit          word_loaded [tfr_pkg::STORE_WORDS];
  bit          mode_8bpp;

  tfr_pkg::res_t pending_rows [$];
  bit            lit_on  = 1'b0;
  tfr_pkg::res_t lit_res = '0;

  int unsigned mismatches, n_checked, cycle_count, mode_writes;
  int unsigned n_load, n_render, n_blank, n_store, n_unknown;
  int unsigned burst_left;
  logic [9:0]  tile_pool [POOL_TILES];

  // Directed table row
  typedef struct {
    bit            mode8;
    tfr_pkg::req_t item;
    bit            has_lit;
    tfr_pkg::res_t lit;
  } dir_step_t;

  dir_step_t dir_steps [$];

  function automatic logic [31:0] nib_swap(input logic [31:0] w);
    logic [31:0] s;
    for (int b = 0; b < 4; b++) s[8*b +: 8] = {w[8*b +: 4], w[8*b+4 +: 4]};
    return s;
  endfunction

  function automatic logic [31:0] byte_rev(input logic [31:0] w);
    logic [31:0] s;
    for (int b = 0; b < 4; b++) s[8*b +: 8] = w[8*(3-b) +: 8];
    return s;
  endfunction

  // Expected row for one transaction; applies loads and stores to the copy
  function automatic tfr_pkg::res_t expected_row(input tfr_pkg::req_t it);
    tfr_pkg::res_t r;
    logic [2:0]    trow;
    logic [13:0]   a4, a8;
    logic [31:0]   lo, hi;
    r    = '0;
    trow = it.vflip ? 3'd7 - it.pixel_row : it.pixel_row;
    a4   = {1'b0, it.tile_index, trow};
    a8   = {it.tile_index, trow, 1'b0};
    case (tfr_pkg::req_e'(it.req_type))
      tfr_pkg::REQ_LOAD: begin
        tile_mem[it.load_address]    = it.load_word;
        word_loaded[it.load_address] = 1'b1;
      end
      tfr_pkg::REQ_RENDER: begin
        if (!mode_8bpp) begin
          r.row_bytes = 4'd4;
          if (it.blank)
            r.row_pixels = it.pixel_row[0] ? 64'h1010_1010 : 64'h0101_0101;
          else
            r.row_pixels = {32'h0, it.hflip ? byte_rev(tile_mem[a4])
                                            : nib_swap(tile_mem[a4])};
        end else begin
          r.row_bytes = 4'd8;
          lo = tile_mem[a8];
          hi = tile_mem[a8 + 14'd1];
          if (it.blank)
            r.row_pixels = it.pixel_row[0] ? 64'h0001_0001_0001_0001
                                           : 64'h0100_0100_0100_0100;
          else if (it.hflip)
            r.row_pixels = {byte_rev(lo), byte_rev(hi)};
          else
            r.row_pixels = {hi, lo};
        end
      end
      tfr_pkg::REQ_STORE: begin
        // write-back only for non-blank 4bpp rows
        if (!mode_8bpp && !it.blank) begin
          tile_mem[a4]    = it.hflip ? byte_rev(it.bitmap_row) : nib_swap(it.bitmap_row);
          word_loaded[a4] = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Flags a non-blank render that would read a word never written
  function automatic bit row_missing(input tfr_pkg::req_t it, output logic [13:0] hole);
    logic [2:0]  trow;
    logic [13:0] a;
    trow = it.vflip ? 3'd7 - it.pixel_row : it.pixel_row;
    hole = '0;
    if (it.req_type != tfr_pkg::REQ_RENDER || it.blank) return 1'b0;
    a = mode_8bpp ? {it.tile_index, trow, 1'b0} : {1'b0, it.tile_index, trow};
    if (!word_loaded[a]) begin
      hole = a;
      return 1'b1;
    end
    if (mode_8bpp && !word_loaded[a + 14'd1]) begin
      hole = a + 14'd1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Result check and prediction on accepted transactions
  always @(posedge clk_i) begin : check_rows
    tfr_pkg::res_t want;
    if (res_valid_o === 1'b1) begin
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected result, row_pixels %h row_bytes %0d",
                 $time, res_o.row_pixels, res_o.row_bytes);
        mismatches++;
      end else begin
        want = pending_rows.pop_front();
        n_checked++;
        if (res_o.row_pixels !== want.row_pixels) begin
          $display("%0t: row_pixels expected %h, actual %h",
                   $time, want.row_pixels, res_o.row_pixels);
          mismatches++;
        end
        if (res_o.row_bytes !== want.row_bytes) begin
          $display("%0t: row_bytes expected %0d, actual %0d",
                   $time, want.row_bytes, res_o.row_bytes);
          mismatches++;
        end
      end
    end
    if (rst_ni && start_i && busy_o === 1'b0) begin
      want = expected_row(req_i);
      pending_rows.push_back(lit_on ? lit_res : want);
      case (tfr_pkg::req_e'(req_i.req_type))
        tfr_pkg::REQ_LOAD:   n_load++;
        tfr_pkg::REQ_RENDER: begin
          n_render++;
          if (req_i.blank) n_blank++;
        end
        tfr_pkg::REQ_STORE:  n_store++;
        default:             n_unknown++;
      endcase
    end
  end

  // Run-away guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_rows.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic add_step(input int unsigned m8, input tfr_pkg::req_e kind,
                          input int unsigned addr, input int unsigned word,
                          input int unsigned tile, input int unsigned hf,
                          input int unsigned vf, input int unsigned bl,
                          input int unsigned prow, input int unsigned brow,
                          input int unsigned has_lit, input longint unsigned pix,
                          input int unsigned nbytes);
    dir_step_t s;
    s.mode8                = 1'(m8);
    s.item.req_type        = kind;
    s.item.load_address    = 14'(addr);
    s.item.load_word       = word;
    s.item.tile_index      = 10'(tile);
    s.item.hflip           = 1'(hf);
    s.item.vflip           = 1'(vf);
    s.item.blank           = 1'(bl);
    s.item.pixel_row       = 3'(prow);
    s.item.bitmap_row      = brow;
    s.has_lit              = 1'(has_lit);
    s.lit.row_pixels       = pix;
    s.lit.row_bytes        = 4'(nbytes);
    dir_steps.push_back(s);
  endtask

  // Drop start and wait for every outstanding result
  task automatic settle();
    start_i <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_mode(input bit m8);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m8;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    mode_8bpp = m8;
    mode_writes++;
  endtask

  // Present one transaction after a random gap, or none in a burst; returns at the falling edge after acceptance
  task automatic issue(input tfr_pkg::req_t it, input bit has_lit, input tfr_pkg::res_t lit);
    int unsigned gap;
    if (burst_left != 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 24) == 0) burst_left = $urandom_range(8, 40);
    end
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= it;
    lit_on  <= has_lit;
    lit_res <= lit;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    @(negedge clk_i);
  endtask

  // Random transaction, biased towards the tile pool
  task automatic next_item(output tfr_pkg::req_t it);
    int unsigned pick;
    logic [13:0] hole;
    logic [9:0]  t;
    it   = {$urandom, $urandom, $urandom};
    t    = ($urandom_range(0, 99) < 85) ? tile_pool[$urandom_range(0, POOL_TILES-1)]
                                        : 10'($urandom_range(0, 1023));
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      it.req_type = tfr_pkg::REQ_NONE;
    end else if (pick < 30) begin
      it.req_type = tfr_pkg::REQ_LOAD;
      if ($urandom_range(0, 4) != 0)
        it.load_address = mode_8bpp ? {t, 4'($urandom_range(0, 15))}
                                    : {1'b0, t, 3'($urandom_range(0, 7))};
    end else if (pick < 80) begin
      it.req_type   = tfr_pkg::REQ_RENDER;
      it.tile_index = t;
      it.blank      = ($urandom_range(0, 6) == 0);
    end else begin
      it.req_type   = tfr_pkg::REQ_STORE;
      it.tile_index = t;
      it.blank      = ($urandom_range(0, 6) == 0);
    end
    // fill the missing word first so renders never read undefined data
    if (row_missing(it, hole)) begin
      it.req_type     = tfr_pkg::REQ_LOAD;
      it.load_address = hole;
    end
  endtask

  initial begin : stimulus
    tfr_pkg::req_t it;
    tfr_pkg::res_t none;
    none = '0;

    // 4bpp: grid, loads at both ends and the middle of the store, flips, write-back, unknown
    add_step(0, tfr_pkg::REQ_RENDER, 0, 0, 0, 0, 0, 1, 0, 0, 1, 64'h0101_0101, 4);
    add_step(0, tfr_pkg::REQ_RENDER, 0, 0, 1023, 1, 1, 1, 7, 0, 1, 64'h1010_1010, 4);
    add_step(0, tfr_pkg::REQ_LOAD, 0, 32'h1234_5678, 0, 0, 0, 0, 0, 0, 1, 0, 0);
    add_step(0, tfr_pkg::REQ_LOAD, 16383, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 1, 0, 0);
    add_step(0, tfr_pkg::REQ_LOAD, 8191, 32'hA5C3_0F81, 0, 0, 0, 0, 0, 0, 1, 0, 0);
    add_step(0, tfr_pkg::REQ_RENDER, 0, 0, 0, 0, 0, 0, 0, 0, 1, 64'h2143_6587, 4);
    add_step(0, tfr_pkg::REQ_RENDER, 0, 0, 0, 1, 0, 0, 0, 0, 1, 64'h7856_3412, 4);
    add_step(0, tfr_pkg::REQ_RENDER, 0, 0, 1023, 0, 1, 0, 0, 0, 0, 0, 0);
    add_step(0, tfr_pkg::REQ_STORE, 0, 0, 0, 0, 0, 0, 3, 32'hDEAD_BEEF, 1, 0, 0);
    add_step(0, tfr_pkg::REQ_RENDER, 0, 0, 0, 0, 0, 0, 3, 0, 1, 64'hDEAD_BEEF, 4);
    add_step(0, tfr_pkg::REQ_STORE, 0, 0, 0, 1, 1, 0, 4, 32'h0123_4567, 1, 0, 0);
    add_step(0, tfr_pkg::REQ_RENDER, 0, 0, 0, 1, 1, 0, 4, 0, 0, 0, 0);
    add_step(0, tfr_pkg::REQ_STORE, 0, 0, 0, 0, 0, 1, 0, 32'hFFFF_FFFF, 1, 0, 0);
    add_step(0, tfr_pkg::REQ_RENDER, 0, 0, 0, 0, 0, 0, 0, 0, 1, 64'h2143_6587, 4);
    add_step(0, tfr_pkg::REQ_NONE, 16383, 32'hFFFF_FFFF, 1023, 1, 1, 1, 7, 32'hFFFF_FFFF,
             1, 0, 0);
    // 8bpp: grid, two-word rows, mirrored rows, ignored store, last tile
    add_step(1, tfr_pkg::REQ_RENDER, 0, 0, 0, 0, 0, 1, 2, 0, 1, 64'h0100_0100_0100_0100, 8);
    add_step(1, tfr_pkg::REQ_RENDER, 0, 0, 5, 0, 1, 1, 5, 0, 1, 64'h0001_0001_0001_0001, 8);
    add_step(1, tfr_pkg::REQ_LOAD, 16, 32'h0302_0100, 0, 0, 0, 0, 0, 0, 1, 0, 0);
    add_step(1, tfr_pkg::REQ_LOAD, 17, 32'h0706_0504, 0, 0, 0, 0, 0, 0, 1, 0, 0);
    add_step(1, tfr_pkg::REQ_RENDER, 0, 0, 1, 0, 0, 0, 0, 0, 1, 64'h0706_0504_0302_0100, 8);
    add_step(1, tfr_pkg::REQ_RENDER, 0, 0, 1, 1, 0, 0, 0, 0, 1, 64'h0001_0203_0405_0607, 8);
    add_step(1, tfr_pkg::REQ_STORE, 0, 0, 1, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, 0);
    add_step(1, tfr_pkg::REQ_RENDER, 0, 0, 1, 0, 1, 0, 7, 0, 0, 0, 0);
    add_step(1, tfr_pkg::REQ_LOAD, 16382, 32'h8000_0001, 0, 0, 0, 0, 0, 0, 1, 0, 0);
    add_step(1, tfr_pkg::REQ_RENDER, 0, 0, 1023, 1, 0, 0, 7, 0, 0, 0, 0);
    add_step(1, tfr_pkg::REQ_NONE, 16383, 32'hFFFF_FFFF, 1023, 1, 1, 1, 7, 32'hFFFF_FFFF,
             1, 0, 0);

    // hold reset, then release it on a falling edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_steps[i]) begin
      if (dir_steps[i].mode8 != mode_8bpp) set_mode(dir_steps[i].mode8);
      issue(dir_steps[i].item, dir_steps[i].has_lit, dir_steps[i].lit);
    end

    // random phases, alternating colour mode, fresh tile pool each time
    for (int p = 0; p < PHASES; p++) begin
      set_mode(p[0]);
      tile_pool[0] = 10'd0;
      tile_pool[1] = 10'd1023;
      for (int k = 2; k < POOL_TILES; k++) tile_pool[k] = 10'($urandom_range(0, 1023));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        next_item(it);
        issue(it, 1'b0, none);
      end
    end

    settle();
    repeat (4) @(posedge clk_i);

    $display("%0d transactions: %0d loads, %0d renders (%0d blank), %0d stores, %0d unknown",
             n_load + n_render + n_store + n_unknown, n_load, n_render, n_blank,
             n_store, n_unknown);
    $display("%0d colour mode writes, %0d results compared", mode_writes, n_checked);
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/tfr_pkg.sv
design/tfr_ram.sv
design/tfr_ctrl.sv
design/tfr_fmt.sv
design/tile_row_fetch_with_flip_core.sv
tb/tile_row_fetch_with_flip_core_test.sv
